### design/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  // fixed geometry of the unit
  localparam int MATRIX_SIZE = 3;
  localparam int CELLS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int ADDR_W      = 4;
  localparam int ELEM_W      = 32;
  localparam int OPND_W      = ELEM_W + 1;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int COF_W       = 2 * ELEM_W + 1;
  localparam int MAG_W       = 2 * ELEM_W;
  localparam int ACC_W       = 99;
  localparam int DMAG_W      = ACC_W - 1;
  localparam int NUM_OPS     = 24;
  localparam int OP_W        = 5;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [OP_W-1:0]   LAST_OP   = OP_W'(NUM_OPS - 1);

  // second multiplier operand source
  typedef enum logic [1:0] {
    BSEL_MAT = 2'd0,
    BSEL_LO  = 2'd1,
    BSEL_HI  = 2'd2
  } bsel_t;

  // one multiply-accumulate step
  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] cof_addr;
    bsel_t             bsel;
    logic              sub;
    logic              clr;
    logic              shift;
    logic              wr;
    logic [ADDR_W-1:0] wr_addr;
    logic              det_end;
  } uop_t;

  // Steps 0..17: adjugate entries, two products each, stored at the
  // adjugate index. Steps 18..23: determinant along the first row,
  // each cofactor split into low and high halves.
  function automatic uop_t uop_lookup(input logic [OP_W-1:0] n);
    uop_t u;
    int   kk;
    int   s;
    int   ci;
    int   cj;
    int   r0;
    int   r1;
    int   c0;
    int   c1;
    int   j;
    int   h;
    u = '0;
    u.bsel = BSEL_MAT;
    for (kk = 0; kk < CELLS; kk++) begin
      for (s = 0; s < 2; s++) begin
        if (n == OP_W'(2 * kk + s)) begin
          ci = kk % MATRIX_SIZE;
          cj = kk / MATRIX_SIZE;
          r0 = (ci == 0) ? 1 : 0;
          r1 = (ci == 2) ? 1 : 2;
          c0 = (cj == 0) ? 1 : 0;
          c1 = (cj == 2) ? 1 : 2;
          if (s == 0) begin
            u.addr_a = ADDR_W'(r0 * MATRIX_SIZE + c0);
            u.addr_b = ADDR_W'(r1 * MATRIX_SIZE + c1);
          end else begin
            u.addr_a = ADDR_W'(r0 * MATRIX_SIZE + c1);
            u.addr_b = ADDR_W'(r1 * MATRIX_SIZE + c0);
          end
          u.sub     = ((s == 1) != (((ci + cj) % 2) == 1));
          u.clr     = (s == 0);
          u.wr      = (s == 1);
          u.wr_addr = ADDR_W'(kk);
        end
      end
    end
    for (j = 0; j < MATRIX_SIZE; j++) begin
      for (h = 0; h < 2; h++) begin
        if (n == OP_W'(2 * CELLS + 2 * j + h)) begin
          u.addr_a   = ADDR_W'(j);
          u.cof_addr = ADDR_W'(j * MATRIX_SIZE);
          u.bsel     = (h == 1) ? BSEL_HI : BSEL_LO;
          u.shift    = (h == 1);
          u.clr      = (j == 0 && h == 0);
          u.det_end  = (j == MATRIX_SIZE - 1 && h == 1);
        end
      end
    end
    return u;
  endfunction

endpackage
`default_nettype wire

### design/matrix_inverse_3x3_unit.sv
// 3x3 matrix inverse, adjugate over determinant, signed fixed point.
// Load: one element per cycle; in_ready is high only while loading.
// After the ninth element: 24 multiply-accumulate steps, each through the
// issue, multiply and accumulate states, then the check state; then per
// result a fetch state, a divider start state and the divider run, and
// the result is held until taken. A singular matrix gives one result.
// Synchronous reset returns to loading with an empty element count.
`default_nettype none
module matrix_inverse_3x3_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] element_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      inverse_value,
  output logic             singular,
  output logic             last
);

  localparam int AW = mi3_pkg::ADDR_W;

  typedef enum logic [7:0] {
    ST_LOAD   = 8'b0000_0001,
    ST_ISSUE  = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_ACC    = 8'b0000_1000,
    ST_CHECK  = 8'b0001_0000,
    ST_FETCH  = 8'b0010_0000,
    ST_DSTART = 8'b0100_0000,
    ST_DWAIT  = 8'b1000_0000
  } state_t;

  state_t state;
  logic [AW-1:0]                 load_count;
  logic [mi3_pkg::OP_W-1:0]      op_n;
  logic [AW-1:0]                 k;
  mi3_pkg::uop_t                 uop;

  // element store and adjugate store
  logic [mi3_pkg::ELEM_W-1:0] mat_mem [mi3_pkg::CELLS];
  logic [mi3_pkg::COF_W-1:0]  cof_mem [mi3_pkg::CELLS];
  logic [mi3_pkg::ELEM_W-1:0] mat_rd_a;
  logic [mi3_pkg::ELEM_W-1:0] mat_rd_b;
  logic [mi3_pkg::COF_W-1:0]  cof_rd;
  logic [AW-1:0]              cof_raddr;

  logic signed [mi3_pkg::OPND_W-1:0] opnd_a;
  logic signed [mi3_pkg::OPND_W-1:0] opnd_b;
  logic signed [mi3_pkg::PROD_W-1:0] prod;
  logic signed [mi3_pkg::ACC_W-1:0]  acc;
  logic signed [mi3_pkg::ACC_W-1:0]  acc_next;
  logic signed [mi3_pkg::ACC_W-1:0]  term;
  logic signed [mi3_pkg::ACC_W-1:0]  det;
  logic [mi3_pkg::ACC_W-1:0]         det_abs;
  logic [mi3_pkg::DMAG_W-1:0]        det_mag;
  logic                              det_neg;
  logic [mi3_pkg::COF_W-1:0]         adj_abs;
  logic                              div_start;
  logic                              div_done;
  logic [mi3_pkg::ELEM_W-1:0]        div_result;

  assign uop      = mi3_pkg::uop_lookup(op_n);
  assign in_ready = (state == ST_LOAD) && !out_valid;

  // memory ports
  assign cof_raddr = (state == ST_FETCH || state == ST_DSTART) ? k : uop.cof_addr;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mat_mem[load_count] <= element_value;
    end
    mat_rd_a <= mat_mem[uop.addr_a];
    mat_rd_b <= mat_mem[uop.addr_b];
  end

  always_ff @(posedge clk) begin
    if (state == ST_ACC && uop.wr) begin
      cof_mem[uop.wr_addr] <= acc_next[mi3_pkg::COF_W-1:0];
    end
    cof_rd <= cof_mem[cof_raddr];
  end

  // multiplier operands
  assign opnd_a = $signed({mat_rd_a[mi3_pkg::ELEM_W-1], mat_rd_a});
  always_comb begin
    case (uop.bsel)
      mi3_pkg::BSEL_LO: opnd_b = $signed({1'b0, cof_rd[mi3_pkg::ELEM_W-1:0]});
      mi3_pkg::BSEL_HI: opnd_b = $signed(cof_rd[mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]);
      default:          opnd_b = $signed({mat_rd_b[mi3_pkg::ELEM_W-1], mat_rd_b});
    endcase
  end

  // accumulate
  always_comb begin
    term = mi3_pkg::ACC_W'(prod);
    if (uop.shift) begin
      term = term <<< mi3_pkg::ELEM_W;
    end
    if (uop.clr) begin
      acc_next = uop.sub ? -term : term;
    end else begin
      acc_next = uop.sub ? (acc - term) : (acc + term);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= opnd_a * opnd_b;
    end
    if (state == ST_ACC) begin
      acc <= acc_next;
      if (uop.det_end) begin
        det <= acc_next;
      end
    end
    if (state == ST_CHECK) begin
      det_mag <= det_abs[mi3_pkg::DMAG_W-1:0];
      det_neg <= det[mi3_pkg::ACC_W-1];
    end
  end

  assign det_abs   = det[mi3_pkg::ACC_W-1] ? -det : det;
  assign adj_abs   = cof_rd[mi3_pkg::COF_W-1] ? -cof_rd : cof_rd;
  assign div_start = (state == ST_DSTART);

  mi3_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag (adj_abs[mi3_pkg::MAG_W-1:0]),
    .num_neg (cof_rd[mi3_pkg::COF_W-1]),
    .den_mag (det_mag),
    .den_neg (det_neg),
    .done    (div_done),
    .result  (div_result)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      op_n       <= '0;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
        if (singular || k == mi3_pkg::LAST_CELL) begin
          state <= ST_LOAD;
        end else begin
          k     <= k + 1'b1;
          state <= ST_FETCH;
        end
      end
      case (state)
        ST_LOAD: begin
          if (in_valid && in_ready) begin
            if (load_count == mi3_pkg::LAST_CELL) begin
              load_count <= '0;
              op_n       <= '0;
              state      <= ST_ISSUE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        ST_ISSUE: state <= ST_MUL;
        ST_MUL:   state <= ST_ACC;
        ST_ACC: begin
          if (op_n == mi3_pkg::LAST_OP) begin
            state <= ST_CHECK;
          end else begin
            op_n  <= op_n + 1'b1;
            state <= ST_ISSUE;
          end
        end
        ST_CHECK: begin
          k <= '0;
          if (det == '0) begin
            inverse_value <= '0;
            singular      <= 1'b1;
            last          <= 1'b1;
            out_valid     <= 1'b1;
            state         <= ST_LOAD;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH:  state <= ST_DSTART;
        ST_DSTART: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            inverse_value <= div_result;
            singular      <= 1'b0;
            last          <= (k == mi3_pkg::LAST_CELL);
            out_valid     <= 1'b1;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // while a result waits, the sequencer sits in the load state unable to load
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_singular_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> last)
    else $error("singular result not marked last");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !singular |-> k == mi3_pkg::LAST_CELL)
    else $error("last flag on wrong inverse entry");

  a_start_compute: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && load_count == mi3_pkg::LAST_CELL |=> state == ST_ISSUE)
    else $error("ninth element did not start the computation");

endmodule
`default_nettype wire

### design/mi3_div.sv
`default_nettype none
module mi3_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mi3_pkg::MAG_W-1:0]     num_mag,
  input  wire logic                          num_neg,
  input  wire logic [mi3_pkg::DMAG_W-1:0]    den_mag,
  input  wire logic                          den_neg,
  output logic                               done,
  output logic [mi3_pkg::ELEM_W-1:0]         result
);

  localparam int NUM_W = mi3_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int REM_W = mi3_pkg::DMAG_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [REM_W-1:0] rem_sh;
  logic             fits;
  logic             nz;
  logic             ovf_pos;
  logic             ovf_neg;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem[REM_W-2:0], nq[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= {num_mag, {(2 * FRAC_BITS){1'b0}}};
      rem <= '0;
      neg <= num_neg ^ den_neg;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, den_mag}) : rem_sh;
      nq  <= {nq[NUM_W-2:0], fits};
    end
  end

  // sign and saturation of the quotient
  assign nz      = |nq;
  assign ovf_pos = |nq[NUM_W-1:31];
  assign ovf_neg = (|nq[NUM_W-1:32]) || (nq[31] && (|nq[30:0]));

  always_comb begin
    if (neg && nz) begin
      result = ovf_neg ? 32'h8000_0000 : (~nq[31:0] + 32'd1);
    end else begin
      result = ovf_pos ? 32'h7FFF_FFFF : nq[31:0];
    end
  end

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Expected inverse entries, in the order the unit must emit them
class inverse_scoreboard;
  logic [31:0] exp_value[$];
  logic        exp_singular[$];
  logic        exp_last[$];
  logic [31:0] loaded[9];
  int          load_cnt;
  int          mismatches;

  function new();
    load_cnt   = 0;
    mismatches = 0;
  endfunction

  // signed 2x2 cofactor of entry (i, j)
  function automatic logic signed [127:0] cofactor(int i, int j);
    int rs[2];
    int cs[2];
    int nr;
    int nc;
    logic signed [127:0] p;
    logic signed [127:0] q;
    nr = 0;
    nc = 0;
    for (int k = 0; k < 3; k++) begin
      if (k != i) begin
        rs[nr] = k;
        nr++;
      end
      if (k != j) begin
        cs[nc] = k;
        nc++;
      end
    end
    p = 128'(signed'(loaded[rs[0]*3+cs[0]])) * 128'(signed'(loaded[rs[1]*3+cs[1]]));
    q = 128'(signed'(loaded[rs[0]*3+cs[1]])) * 128'(signed'(loaded[rs[1]*3+cs[0]]));
    cofactor = p - q;
    if ((i + j) % 2 == 1) cofactor = -cofactor;
  endfunction

  // accepted element; on the ninth, queue the inverse
  function void note_element(logic [31:0] v);
    logic signed [127:0] det;
    logic signed [127:0] adj;
    logic [127:0]        adet;
    logic [127:0]        amag;
    logic [127:0]        quo;
    logic                neg;
    logic [31:0]         r;
    loaded[load_cnt] = v;
    load_cnt++;
    if (load_cnt < 9) return;
    load_cnt = 0;
    det = 0;
    for (int j = 0; j < 3; j++)
      det += 128'(signed'(loaded[j])) * cofactor(0, j);
    if (det == 0) begin
      exp_value.push_back(32'd0);
      exp_singular.push_back(1'b1);
      exp_last.push_back(1'b1);
      return;
    end
    adet = (det < 0) ? -det : det;
    for (int k = 0; k < 9; k++) begin
      adj  = cofactor(k % 3, k / 3);
      amag = (adj < 0) ? -adj : adj;
      quo  = (amag << 32) / adet;
      neg  = ((adj < 0) != (det < 0)) && (quo != 0);
      if (neg) r = (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
      else r = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      exp_value.push_back(r);
      exp_singular.push_back(1'b0);
      exp_last.push_back(k == 8);
    end
  endfunction

  function void check_result(logic [31:0] v, logic s, logic l);
    if (exp_value.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h s=%b l=%b", v, s, l);
      return;
    end
    if (v !== exp_value[0] || s !== exp_singular[0] || l !== exp_last[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %h s=%b l=%b, got %h s=%b l=%b",
                 exp_value[0], exp_singular[0], exp_last[0], v, s, l);
    end
    void'(exp_value.pop_front());
    void'(exp_singular.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] element_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] inverse_value;
  logic        singular;
  logic        last;

  inverse_scoreboard sb;
  int  cycles;
  int  burst_left;
  bit  stall_free;

  matrix_inverse_3x3_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .element_value(element_value), .out_valid(out_valid), .out_ready(out_ready),
    .inverse_value(inverse_value), .singular(singular), .last(last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) sb.note_element(element_value);
    if (!rst && out_valid && out_ready) sb.check_result(inverse_value, singular, last);
    if (cycles > 1500000) begin
      $display("matrix_inverse_3x3_unit regression: fail");
      $finish;
    end
  end

  // receiver stall pattern; some stretches never stall
  always @(negedge clk) begin
    if (cycles % 4000 < 1000) out_ready <= 1'b1;
    else if (cycles % 4000 < 2500) out_ready <= (cycles % 7) != 3;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  // one transaction on the element channel, bursts with gaps between;
  // valid stays up inside a burst and drops only for a gap
  task automatic send_element(logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_matrix(logic [31:0] m[9]);
    for (int k = 0; k < 9; k++) send_element(m[k]);
  endtask

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: rand_elem = $urandom();
      1: rand_elem = 32'($signed($urandom_range(0, 8)) - 4) << 16;
      2: rand_elem = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: rand_elem = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [31:0] m[9];
    int kind;
    sb            = new();
    cycles        = 0;
    burst_left    = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    element_value = 32'd0;
    out_ready     = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity
    m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_matrix(m);
    // all zero: singular
    m = '{default: 32'd0};
    send_matrix(m);
    // rank-deficient: equal rows
    m = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
          32'h40000, 32'h50000, 32'h70000};
    send_matrix(m);
    // tiny diagonal: inverse saturates positive and negative
    m = '{32'd1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'd1};
    send_matrix(m);
    // extremes on the diagonal
    m = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000};
    send_matrix(m);

    // random matrices, mixed element styles
    for (int n = 0; n < 32; n++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        m[k] = rand_elem(kind < 3 ? 0 : kind < 6 ? 1 : kind < 9 ? 2 : $urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0)
        for (int k = 0; k < 3; k++) m[6 + k] = m[k];
      send_matrix(m);
    end
    in_valid <= 1'b0;

    while (sb.exp_value.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) $display("matrix_inverse_3x3_unit regression: pass");
    else $display("matrix_inverse_3x3_unit regression: fail");
    $finish;
  end
endmodule

### files.f
design/mi3_pkg.sv
design/mi3_div.sv
design/matrix_inverse_3x3_unit.sv
bench/tb_top.sv
